@@ hdl/psrc_pkg.sv @@
package psrc_pkg;

    localparam int MAX_N   = 1024;
    localparam int ADDR_W  = $clog2(MAX_N);
    localparam int FIELD_W = 11;
    localparam int ENTRY_W = FIELD_W + 1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SWAP = 1'b1;

    localparam logic REG_SIZE = 1'b0;
    localparam logic [FIELD_W-1:0] SIZE_RESET = FIELD_W'(1);

    // position-of-value entry: {generation mark, position}
    typedef struct packed {
        logic               vap_we;
        logic [ADDR_W-1:0]  vap_waddr;
        logic [FIELD_W-1:0] vap_wdata;
        logic [ADDR_W-1:0]  vap_raddr_a;
        logic [ADDR_W-1:0]  vap_raddr_b;
        logic               pov_we;
        logic [ADDR_W-1:0]  pov_waddr;
        logic [ENTRY_W-1:0] pov_wdata;
        logic [ADDR_W-1:0]  pov_raddr_a;
        logic [ADDR_W-1:0]  pov_raddr_b;
    } tbl_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] vap_a;
        logic [FIELD_W-1:0] vap_b;
        logic [ENTRY_W-1:0] pov_a;
        logic [ENTRY_W-1:0] pov_b;
    } tbl_rsp_t;

endpackage

@@ hdl/permutation_swap_run_counter.sv @@
// Ascending-run counter over a permutation held in two tables.
// Item channel: item_valid/item_stall with command, first, value, pos_a,
// pos_b. A load (command 0) places value at the next position and gives
// no result. A swap (command 1) exchanges two positions and gives one
// result, rounds, on result_valid/result_stall.
// Size register (n) at APB address 0; pready is always high.
// One item is taken at a time: item_stall is high from acceptance until
// the block is idle again, after S_LOAD and S_LCHK for a load and after
// S_SWAP to S_DONE for a swap (fewer when positions or values are rejected).
// A swap makes six position-table reads, two per cycle on the two read ports,
// then writes back in S_CALC and S_WR2; its result is registered from S_DONE.
// A result sits in an output register; the next item is accepted while it
// waits. A swap that finishes while that register is still full holds
// until result_stall drops.
// After reset the block sweeps every position-table entry to clear the
// generation marks, with item_stall high. Config writes are taken then.
module permutation_swap_run_counter
    import psrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               command,
    input  logic               first,
    input  logic [FIELD_W-1:0] value,
    input  logic [FIELD_W-1:0] pos_a,
    input  logic [FIELD_W-1:0] pos_b,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [FIELD_W-1:0] rounds
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_LCHK, S_SWAP,
        S_P0, S_P1, S_P2, S_P3, S_CALC, S_WR2, S_DONE
    } state_t;

    localparam logic [FIELD_W-1:0] N_MAX = FIELD_W'(MAX_N);
    localparam logic [FIELD_W-1:0] ONE   = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] TWO   = FIELD_W'(2);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [FIELD_W-1:0] k);
        logic [FIELD_W-1:0] km;
        km = k - ONE;
        return km[ADDR_W-1:0];
    endfunction

    state_t             state_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic [FIELD_W-1:0] size_reg;
    logic               gen_reg;
    logic [FIELD_W-1:0] lpos_reg;
    logic [FIELD_W-1:0] count_reg;
    logic               cmd_reg;
    logic               first_reg;
    logic [FIELD_W-1:0] value_reg;
    logic [FIELD_W-1:0] pa_reg;
    logic [FIELD_W-1:0] pb_reg;
    logic [FIELD_W-1:0] u_reg;
    logic [FIELD_W-1:0] v_reg;
    logic [FIELD_W-1:0] lo_reg;
    logic [FIELD_W-1:0] hi_reg;
    logic [FIELD_W-1:0] p_reg [6];
    logic               g_lo_reg;
    logic               g_hi_reg;
    logic               chk_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] rounds_reg;

    tbl_req_t req;
    tbl_rsp_t rsp;

    logic [FIELD_W-1:0] n_eff;
    logic               cfg_wr;
    logic               accept;
    logic               gen_eff;
    logic [FIELD_W-1:0] cnt_base;
    logic [FIELD_W-1:0] lpos_base;
    logic [FIELD_W-1:0] ld_pos;
    logic               ld_ok;
    logic               ld_chk;
    logic               sw_pos_ok;
    logic [FIELD_W-1:0] u_c;
    logic [FIELD_W-1:0] v_c;
    logic               uv_ok;
    logic [FIELD_W-1:0] lo_c;
    logic [FIELD_W-1:0] hi_c;
    logic [FIELD_W-1:0] q2;
    logic [FIELD_W-1:0] q3;
    logic               lo_edge;
    logic               hi_edge;
    logic               adj;
    logic [2:0]         removed;
    logic [2:0]         added;
    logic [FIELD_W-1:0] count_swap;
    logic               out_free;

    psrc_tables u_tables (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite && (paddr[2] == REG_SIZE);
    assign prdata       = (paddr[2] == REG_SIZE) ? 32'(size_reg) : 32'd0;
    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign rounds       = rounds_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (size_reg == '0)
            n_eff = ONE;
        else if (size_reg > N_MAX)
            n_eff = N_MAX;
        else
            n_eff = size_reg;
    end

    // load
    assign gen_eff   = first_reg ? ~gen_reg : gen_reg;
    assign cnt_base  = first_reg ? ONE : count_reg;
    assign lpos_base = first_reg ? '0 : lpos_reg;
    assign ld_pos    = lpos_base + ONE;
    assign ld_ok     = (ld_pos <= n_eff) && (value_reg != '0) && (value_reg <= n_eff);
    assign ld_chk    = ld_ok && (value_reg < n_eff);

    // swap
    assign sw_pos_ok = (pa_reg != '0) && (pa_reg <= n_eff) && (pb_reg != '0)
                       && (pb_reg <= n_eff) && (pa_reg != pb_reg);
    assign u_c   = rsp.vap_a;
    assign v_c   = rsp.vap_b;
    assign uv_ok = (u_c != '0) && (u_c <= n_eff) && (v_c != '0) && (v_c <= n_eff)
                   && (u_c != v_c);
    assign lo_c  = (u_c < v_c) ? u_c : v_c;
    assign hi_c  = (u_c < v_c) ? v_c : u_c;

    // p_reg: old positions of lo-1, lo, lo+1, hi-1, hi, hi+1
    assign adj     = (lo_reg + ONE == hi_reg);
    assign lo_edge = (lo_reg >= TWO);
    assign hi_edge = (hi_reg < n_eff);
    assign q2      = adj ? p_reg[1] : p_reg[2];
    assign q3      = adj ? p_reg[4] : p_reg[3];

    always_comb
    begin
        removed = 3'(lo_edge && (p_reg[0] > p_reg[1]))
                + 3'(p_reg[1] > p_reg[2])
                + 3'(!adj && (p_reg[3] > p_reg[4]))
                + 3'(hi_edge && (p_reg[4] > p_reg[5]));
        added   = 3'(lo_edge && (p_reg[0] > p_reg[4]))
                + 3'(p_reg[4] > q2)
                + 3'(!adj && (q3 > p_reg[1]))
                + 3'(hi_edge && (p_reg[1] > p_reg[5]));
        count_swap = count_reg - FIELD_W'(removed) + FIELD_W'(added);
    end

    always_comb
    begin
        req = '0;
        case (state_reg)
            S_CLEAR:
            begin
                req.pov_we    = 1'b1;
                req.pov_waddr = clr_reg;
            end
            S_LOAD:
            begin
                req.vap_we      = ld_ok;
                req.vap_waddr   = addr_of(ld_pos);
                req.vap_wdata   = value_reg;
                req.pov_we      = ld_ok;
                req.pov_waddr   = addr_of(value_reg);
                req.pov_wdata   = {gen_eff, ld_pos};
                req.pov_raddr_a = value_reg[ADDR_W-1:0];
            end
            S_SWAP:
            begin
                req.vap_raddr_a = addr_of(pa_reg);
                req.vap_raddr_b = addr_of(pb_reg);
            end
            S_P0:
            begin
                req.pov_raddr_a = addr_of(lo_c - ONE);
                req.pov_raddr_b = addr_of(lo_c);
            end
            S_P1:
            begin
                req.pov_raddr_a = lo_reg[ADDR_W-1:0];
                req.pov_raddr_b = addr_of(hi_reg - ONE);
            end
            S_P2:
            begin
                req.pov_raddr_a = addr_of(hi_reg);
                req.pov_raddr_b = hi_reg[ADDR_W-1:0];
            end
            S_CALC:
            begin
                req.pov_we    = 1'b1;
                req.pov_waddr = addr_of(lo_reg);
                req.pov_wdata = {g_lo_reg, p_reg[4]};
                req.vap_we    = 1'b1;
                req.vap_waddr = addr_of(pa_reg);
                req.vap_wdata = v_reg;
            end
            S_WR2:
            begin
                req.pov_we    = 1'b1;
                req.pov_waddr = addr_of(hi_reg);
                req.pov_wdata = {g_hi_reg, p_reg[1]};
                req.vap_we    = 1'b1;
                req.vap_waddr = addr_of(pb_reg);
                req.vap_wdata = u_reg;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            size_reg      <= SIZE_RESET;
            gen_reg       <= 1'b0;
            lpos_reg      <= '0;
            count_reg     <= ONE;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                size_reg <= pwdata[FIELD_W-1:0];
            end
            if (out_valid_reg && !result_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= command;
                        first_reg <= first;
                        value_reg <= value;
                        pa_reg    <= pos_a;
                        pb_reg    <= pos_b;
                        state_reg <= (command == CMD_SWAP) ? S_SWAP : S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    gen_reg   <= gen_eff;
                    count_reg <= cnt_base;
                    lpos_reg  <= ld_ok ? ld_pos : lpos_base;
                    chk_reg   <= ld_chk;
                    state_reg <= S_LCHK;
                end
                S_LCHK:
                begin
                    if (chk_reg && (rsp.pov_a[ENTRY_W-1] == gen_reg))
                        count_reg <= count_reg + ONE;
                    state_reg <= S_IDLE;
                end
                S_SWAP:
                begin
                    state_reg <= sw_pos_ok ? S_P0 : S_DONE;
                end
                S_P0:
                begin
                    u_reg     <= u_c;
                    v_reg     <= v_c;
                    lo_reg    <= lo_c;
                    hi_reg    <= hi_c;
                    state_reg <= uv_ok ? S_P1 : S_DONE;
                end
                S_P1:
                begin
                    p_reg[0]  <= rsp.pov_a[FIELD_W-1:0];
                    p_reg[1]  <= rsp.pov_b[FIELD_W-1:0];
                    g_lo_reg  <= rsp.pov_b[ENTRY_W-1];
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    p_reg[2]  <= rsp.pov_a[FIELD_W-1:0];
                    p_reg[3]  <= rsp.pov_b[FIELD_W-1:0];
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    p_reg[4]  <= rsp.pov_a[FIELD_W-1:0];
                    g_hi_reg  <= rsp.pov_a[ENTRY_W-1];
                    p_reg[5]  <= rsp.pov_b[FIELD_W-1:0];
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    count_reg <= count_swap;
                    state_reg <= S_WR2;
                end
                S_WR2:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        rounds_reg    <= count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // cmd_reg kept for the item record; loads and swaps are split by state
    a_cmd_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (cmd_reg == CMD_LOAD))
        else $error("load state entered for a swap item");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_distinct_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> (lo_reg != hi_reg) && (pa_reg != pb_reg))
        else $error("swap write-back to a single entry");

    a_swap_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP) |=> (state_reg == S_P0 || state_reg == S_DONE))
        else $error("swap sequencing broken");

endmodule

@@ hdl/psrc_tables.sv @@
module psrc_tables
    import psrc_pkg::*;
(
    input  logic     clk,
    input  tbl_req_t req,
    output tbl_rsp_t rsp
);

    logic [FIELD_W-1:0] vap_mem [MAX_N];
    logic [ENTRY_W-1:0] pov_mem [MAX_N];

    logic [FIELD_W-1:0] vap_a_reg;
    logic [FIELD_W-1:0] vap_b_reg;
    logic [ENTRY_W-1:0] pov_a_reg;
    logic [ENTRY_W-1:0] pov_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.vap_we)
        begin
            vap_mem[req.vap_waddr] <= req.vap_wdata;
        end
        vap_a_reg <= vap_mem[req.vap_raddr_a];
        vap_b_reg <= vap_mem[req.vap_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (req.pov_we)
        begin
            pov_mem[req.pov_waddr] <= req.pov_wdata;
        end
        pov_a_reg <= pov_mem[req.pov_raddr_a];
        pov_b_reg <= pov_mem[req.pov_raddr_b];
    end

    assign rsp = {vap_a_reg, vap_b_reg, pov_a_reg, pov_b_reg};

endmodule
